>>> src/utf8d_pkg.sv
package utf8d_pkg;

    // replacement code point U+FFFD
    localparam logic [20:0] REPL_CP = 21'h00FFFD;

    // result queue depth; an item needs room for two results
    localparam int unsigned QDEPTH     = 4;
    localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);
    localparam int unsigned QIDX_W     = $clog2(QDEPTH);
    localparam int unsigned MAX_RESULTS = 2;

    // one decoded result item
    typedef struct packed {
        logic [20:0] code_point;
        logic        is_replacement;
        logic        last_of_run;
    } t_result;

    // results caused by one input item
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step_out;

endpackage

>>> src/utf8d_step.sv
module utf8d_step (
    input  logic [7:0]           i_in_byte,
    input  logic                 i_end_of_text,
    input  logic [1:0]           i_pending,
    input  logic [14:0]          i_partial,
    output logic [1:0]           o_pending,
    output logic [14:0]          o_partial,
    output utf8d_pkg::t_step_out o_step
);

    function automatic utf8d_pkg::t_result make_result(
        input logic [20:0] cp,
        input logic        rep
    );
        utf8d_pkg::t_result r;
        r.code_point     = cp;
        r.is_replacement = rep;
        r.last_of_run    = 1'b0;
        return r;
    endfunction

    logic                  forbidden;
    logic [20:0]           assembled;
    utf8d_pkg::t_result    res0;
    utf8d_pkg::t_result    res1;
    logic [1:0]            cnt;
    logic [1:0]            pend;
    logic [14:0]           part;

    assign forbidden = (i_in_byte == 8'hC0) || (i_in_byte == 8'hC1) || (i_in_byte >= 8'hF5);
    assign assembled = {i_partial, i_in_byte[5:0]};

    // classify the byte and update the pending sequence
    always_comb begin
        res0 = '0;
        res1 = '0;
        cnt  = 2'd0;
        pend = i_pending;
        part = i_partial;

        if (forbidden) begin
            res0 = make_result(utf8d_pkg::REPL_CP, 1'b1);
            cnt  = 2'd1;
            pend = 2'd0;
            part = '0;
        end else if (!i_in_byte[7]) begin
            // ascii, possibly cutting a sequence short
            if (i_pending != 2'd0) begin
                res0 = make_result(utf8d_pkg::REPL_CP, 1'b1);
                res1 = make_result({13'd0, i_in_byte}, 1'b0);
                cnt  = 2'd2;
                pend = 2'd0;
                part = '0;
            end else begin
                res0 = make_result({13'd0, i_in_byte}, 1'b0);
                cnt  = 2'd1;
            end
        end else if (i_in_byte[6]) begin
            // lead byte
            if (i_pending != 2'd0) begin
                res0 = make_result(utf8d_pkg::REPL_CP, 1'b1);
                cnt  = 2'd1;
            end
            if (!i_in_byte[5]) begin
                part = {10'd0, i_in_byte[4:0]};
                pend = 2'd1;
            end else if (!i_in_byte[4]) begin
                part = {11'd0, i_in_byte[3:0]};
                pend = 2'd2;
            end else begin
                part = {12'd0, i_in_byte[2:0]};
                pend = 2'd3;
            end
        end else begin
            // continuation byte
            if (i_pending == 2'd0) begin
                res0 = make_result(utf8d_pkg::REPL_CP, 1'b1);
                cnt  = 2'd1;
            end else begin
                pend = i_pending - 2'd1;
                if (pend == 2'd0) begin
                    res0 = make_result(assembled, 1'b0);
                    cnt  = 2'd1;
                    part = '0;
                end else begin
                    part = assembled[14:0];
                end
            end
        end

        // end of text with an unfinished sequence
        if (i_end_of_text) begin
            if (pend != 2'd0) begin
                if (cnt == 2'd0) begin
                    res0 = make_result(utf8d_pkg::REPL_CP, 1'b1);
                end else begin
                    res1 = make_result(utf8d_pkg::REPL_CP, 1'b1);
                end
                cnt = cnt + 2'd1;
            end
            pend = 2'd0;
            part = '0;
        end

        // flag the final result of this item
        if (cnt == 2'd1) begin
            res0.last_of_run = 1'b1;
        end
        if (cnt == 2'd2) begin
            res1.last_of_run = 1'b1;
        end
    end

    assign o_pending    = pend;
    assign o_partial    = part;
    assign o_step.count = cnt;
    assign o_step.res0  = res0;
    assign o_step.res1  = res1;

endmodule

>>> src/utf8d_outq.sv
module utf8d_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  utf8d_pkg::t_step_out i_step,
    output logic                 o_full,
    output logic                 o_valid,
    input  logic                 i_stall,
    output utf8d_pkg::t_result   o_result
);

    logic [utf8d_pkg::QCNT_W-1:0] r_count;
    logic [utf8d_pkg::QCNT_W-1:0] n_count;
    utf8d_pkg::t_result           r_q [utf8d_pkg::QDEPTH];
    utf8d_pkg::t_result           n_q [utf8d_pkg::QDEPTH];
    logic                         pop;
    logic [utf8d_pkg::QCNT_W-1:0] base;
    logic [utf8d_pkg::QCNT_W-1:0] push_n;

    assign pop    = (r_count != '0) && !i_stall;
    assign push_n = i_push ? utf8d_pkg::QCNT_W'(i_step.count) : '0;
    assign base   = r_count - utf8d_pkg::QCNT_W'(pop);

    // shift out the head, then append the new results behind the survivors
    always_comb begin
        for (int i = 0; i < utf8d_pkg::QDEPTH; i++) begin
            if (pop && (i < utf8d_pkg::QDEPTH - 1)) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
            if ((utf8d_pkg::QCNT_W'(i) == base) && (push_n != '0)) begin
                n_q[i] = i_step.res0;
            end
            if ((utf8d_pkg::QCNT_W'(i) == base + utf8d_pkg::QCNT_W'(1)) &&
                (push_n == utf8d_pkg::QCNT_W'(2))) begin
                n_q[i] = i_step.res1;
            end
        end
        n_count = base + push_n;
    end

    // result storage needs no reset
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < utf8d_pkg::QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_full   = r_count > utf8d_pkg::QCNT_W'(utf8d_pkg::QDEPTH - utf8d_pkg::MAX_RESULTS);
    assign o_valid  = r_count != '0;
    assign o_result = r_q[0];

endmodule

>>> src/utf8_to_codepoint_decoder_unit.sv
// channel | direction | handshake            | payload
// --------+-----------+----------------------+---------------------------------------
// byte in | input     | i_valid / o_stall    | i_in_byte, i_end_of_text
// result  | output    | o_valid / i_stall    | o_code_point, o_is_replacement,
//         |           |                      | o_last_of_run
//
// one byte is accepted per cycle while o_stall is low; its results are registered in
// the result queue and reach the output behind any results already queued; a byte
// yielding two results takes two queue entries, so a stream of them is output-bound
// o_stall rises when the four-entry result queue holds more than two items
// synchronous active-low reset clears the pending sequence and empties the queue
module utf8_to_codepoint_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [20:0] o_code_point,
    output logic        o_is_replacement,
    output logic        o_last_of_run
);

    logic [1:0]           r_pending;
    logic [14:0]          r_partial;
    logic [1:0]           n_pending;
    logic [14:0]          n_partial;
    logic                 accept;
    logic                 q_full;
    utf8d_pkg::t_step_out step;
    utf8d_pkg::t_result   head;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    // byte decode
    utf8d_step u_step (
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .i_pending     (r_pending),
        .i_partial     (r_partial),
        .o_pending     (n_pending),
        .o_partial     (n_partial),
        .o_step        (step)
    );

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_partial <= '0;
        end else if (accept) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
        end
    end

    // result queue
    utf8d_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_step   (step),
        .o_full   (q_full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (head)
    );

    assign o_code_point     = head.code_point;
    assign o_is_replacement = head.is_replacement;
    assign o_last_of_run    = head.last_of_run;

endmodule

>>> dv/utf8_to_codepoint_decoder_unit_tb.sv
module utf8_to_codepoint_decoder_unit_tb;

    // forbidden byte values and ranges
    localparam logic [7:0] BYTE_C0 = 8'hC0;
    localparam logic [7:0] BYTE_C1 = 8'hC1;
    localparam logic [7:0] BYTE_F5 = 8'hF5;
    // continuation byte range
    localparam logic [7:0] CONT_LO = 8'h80;
    localparam logic [7:0] CONT_HI = 8'hBF;
    // long receiver hold for the backpressure test
    localparam int unsigned LONG_HOLD = 45;
    localparam int unsigned DRAIN_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_in_byte;
    logic        i_end_of_text;
    logic        o_valid;
    logic        i_stall;
    logic [20:0] o_code_point;
    logic        o_is_replacement;
    logic        o_last_of_run;

    // decoder state mirror
    logic [1:0]  cont_left;
    logic [14:0] gathered_bits;

    utf8d_pkg::t_result cp_expect_q[$];
    int unsigned        err_cnt;
    int unsigned        bytes_sent;
    bit                 tx_gaps_on;
    bit                 rx_gaps_on;
    int unsigned        rx_hold_req;

    utf8_to_codepoint_decoder_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_in_byte        (i_in_byte),
        .i_end_of_text    (i_end_of_text),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_code_point     (o_code_point),
        .o_is_replacement (o_is_replacement),
        .o_last_of_run    (o_last_of_run)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic utf8d_pkg::t_result make_result(logic [20:0] cp, logic repl);
        utf8d_pkg::t_result r;
        r.code_point     = cp;
        r.is_replacement = repl;
        r.last_of_run    = 1'b0;
        return r;
    endfunction

    // decode one accepted byte and queue the code points it yields
    task automatic decode_byte(input logic [7:0] b, input logic eot);
        utf8d_pkg::t_result res[2];
        int unsigned        n;
        logic [20:0]        assembled;
        n = 0;
        if (b == BYTE_C0 || b == BYTE_C1 || b >= BYTE_F5) begin
            // forbidden byte drops any pending sequence
            res[n] = make_result(utf8d_pkg::REPL_CP, 1'b1);
            n++;
            cont_left     = '0;
            gathered_bits = '0;
        end else if (!b[7]) begin
            // ascii, flagging an interrupted sequence first
            if (cont_left != 0) begin
                res[n] = make_result(utf8d_pkg::REPL_CP, 1'b1);
                n++;
                cont_left     = '0;
                gathered_bits = '0;
            end
            res[n] = make_result({13'd0, b}, 1'b0);
            n++;
        end else if (b[7:6] == 2'b11) begin
            // lead byte starts a new sequence
            if (cont_left != 0) begin
                res[n] = make_result(utf8d_pkg::REPL_CP, 1'b1);
                n++;
            end
            if (b[5] == 1'b0) begin
                gathered_bits = {10'd0, b[4:0]};
                cont_left     = 2'd1;
            end else if (b[4] == 1'b0) begin
                gathered_bits = {11'd0, b[3:0]};
                cont_left     = 2'd2;
            end else begin
                gathered_bits = {12'd0, b[2:0]};
                cont_left     = 2'd3;
            end
        end else begin
            // continuation byte
            if (cont_left == 0) begin
                res[n] = make_result(utf8d_pkg::REPL_CP, 1'b1);
                n++;
            end else begin
                assembled = {gathered_bits, b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 0) begin
                    res[n] = make_result(assembled, 1'b0);
                    n++;
                    gathered_bits = '0;
                end else begin
                    gathered_bits = assembled[14:0];
                end
            end
        end
        // end of text closes any open sequence
        if (eot) begin
            if (cont_left != 0) begin
                res[n] = make_result(utf8d_pkg::REPL_CP, 1'b1);
                n++;
            end
            cont_left     = '0;
            gathered_bits = '0;
        end
        if (n > 0) begin
            res[n - 1].last_of_run = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            cp_expect_q = {cp_expect_q, res[i]};
        end
    endtask

    // offer one byte until accepted, then predict its results
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int unsigned gap;
        gap = 0;
        if (tx_gaps_on && $urandom_range(0, 99) < 25) begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_in_byte     <= b;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (o_stall);
        decode_byte(b, eot);
        bytes_sent++;
    endtask

    // one complete character of random length and content (overlong and surrogate forms not excluded)
    task automatic send_char(input logic eot_at_end);
        int unsigned len;
        logic [7:0]  lead;
        len = $urandom_range(1, 4);
        case (len)
            1: lead = 8'($urandom_range(8'h00, 8'h7F));
            2: lead = 8'($urandom_range(8'hC2, 8'hDF));
            3: lead = 8'($urandom_range(8'hE0, 8'hEF));
            default: lead = 8'($urandom_range(8'hF0, 8'hF4));
        endcase
        send_byte(lead, eot_at_end && len == 1);
        for (int i = 1; i < len; i++) begin
            send_byte(8'($urandom_range(CONT_LO, CONT_HI)), eot_at_end && i == len - 1);
        end
    endtask

    // a sequence cut short, sometimes by end of text
    task automatic send_truncated();
        int unsigned len;
        int unsigned kept;
        logic [7:0]  lead;
        logic        cut_eot;
        len     = $urandom_range(2, 4);
        kept    = $urandom_range(0, len - 2);
        cut_eot = ($urandom_range(0, 3) == 0);
        case (len)
            2: lead = 8'($urandom_range(8'hC2, 8'hDF));
            3: lead = 8'($urandom_range(8'hE0, 8'hEF));
            default: lead = 8'($urandom_range(8'hF0, 8'hF4));
        endcase
        send_byte(lead, cut_eot && kept == 0);
        for (int i = 1; i <= kept; i++) begin
            send_byte(8'($urandom_range(CONT_LO, CONT_HI)), cut_eot && i == kept);
        end
    endtask

    // mixed text: mostly valid characters, some noise and broken sequences
    task automatic run_text(input int unsigned n_bytes);
        int unsigned target;
        int unsigned r;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                send_char($urandom_range(0, 9) == 0);
            end else if (r < 88) begin
                send_truncated();
            end else begin
                send_byte(8'($urandom), $urandom_range(0, 9) == 0);
            end
        end
    endtask

    // extremes, every byte class and each error case
    task automatic test_directed();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // validly encoded replacement is not flagged
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBD, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // forbidden bytes
        send_byte(8'hC0, 1'b0);
        send_byte(8'hC1, 1'b0);
        send_byte(8'hF5, 1'b0);
        send_byte(8'hFF, 1'b1);
        // ascii interrupting a sequence
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        // lead byte interrupting a sequence
        send_byte(8'hE2, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        // stray continuation
        send_byte(8'h80, 1'b0);
        // end of text inside a sequence
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b1);
    endtask

    task automatic test_random_text();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        run_text(1400);
    endtask

    // full rate on both sides, two-result bytes frequent
    task automatic test_back_to_back();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        for (int i = 0; i < 60; i++) begin
            send_byte(8'($urandom_range(8'hC2, 8'hF4)), 1'b0);
            send_byte(8'($urandom_range(8'h00, 8'h7F)), 1'b0);
        end
        run_text(100);
    endtask

    // receiver holds off while the sender keeps offering, filling the queue
    task automatic test_backpressure();
        tx_gaps_on  = 1'b0;
        rx_gaps_on  = 1'b0;
        rx_hold_req = LONG_HOLD;
        for (int i = 0; i < 30; i++) begin
            send_byte(8'($urandom_range(8'hC2, 8'hDF)), 1'b0);
            send_byte(8'($urandom_range(8'h00, 8'h7F)), 1'b0);
        end
        rx_gaps_on = 1'b1;
        run_text(60);
    endtask

    // receiver stall, with random gaps and an occasional long hold
    initial begin
        int unsigned hold_left;
        hold_left   = 0;
        rx_hold_req = 0;
        i_stall    <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (rx_gaps_on && $urandom_range(0, 99) < 20) begin
                hold_left = pick_gap() - 1;
                i_stall  <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        utf8d_pkg::t_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (cp_expect_q.size() == 0) begin
                $error("unexpected item: code_point %0h", o_code_point);
                err_cnt++;
            end else begin
                exp_r = cp_expect_q.pop_front();
                if (o_code_point !== exp_r.code_point) begin
                    $error("code_point expected %0h actual %0h",
                           exp_r.code_point, o_code_point);
                    err_cnt++;
                end
                if (o_is_replacement !== exp_r.is_replacement) begin
                    $error("is_replacement expected %0b actual %0b",
                           exp_r.is_replacement, o_is_replacement);
                    err_cnt++;
                end
                if (o_last_of_run !== exp_r.last_of_run) begin
                    $error("last_of_run expected %0b actual %0b",
                           exp_r.last_of_run, o_last_of_run);
                    err_cnt++;
                end
            end
        end
    end

    // main sequence
    initial begin
        int unsigned waited;
        err_cnt       = 0;
        bytes_sent    = 0;
        waited        = 0;
        tx_gaps_on    = 1'b0;
        rx_gaps_on    = 1'b0;
        cont_left     = '0;
        gathered_bits = '0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_in_byte     <= '0;
        i_end_of_text <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_text();
        test_back_to_back();
        test_backpressure();

        i_valid    <= 1'b0;
        rx_gaps_on = 1'b1;
        while (cp_expect_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (cp_expect_q.size() != 0) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            repeat (20) @(posedge i_clk);
            if (err_cnt == 0) begin
                $display("DONE: 0 errors");
            end else begin
                $display("DONE: errors detected");
            end
            $finish;
        end
    end

endmodule

>>> filelist.f
src/utf8d_pkg.sv
src/utf8d_step.sv
src/utf8d_outq.sv
src/utf8_to_codepoint_decoder_unit.sv
dv/utf8_to_codepoint_decoder_unit_tb.sv
